// ===== hdl/n2a_pkg.sv =====
// ----------------------------------------------------------------------------
// n2a_pkg: shared types and constants for the number to ascii digits core
// character codes, input kind codes, state type and digit-width helpers
// ----------------------------------------------------------------------------
package n2a_pkg;

  localparam int NUMBER_BITS_DEF = 32;

  // ascii codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // kind of conversion carried with each input word
  typedef enum logic [1:0] {
    KIND_UDEC = 2'd0,
    KIND_SDEC = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_BIN  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // decimal digits of the widest nb-bit value: floor(nb * log10(2)) + 1
  function automatic int dec_digits(input int nb);
    return (nb * 30103) / 100000 + 1;
  endfunction

  // hex digits of the widest nb-bit value
  function automatic int hex_digits(input int nb);
    return (nb + 3) / 4;
  endfunction

  // one digit value (0..15) to its ascii code
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] code;
    if (d < 4'd10) begin
      code = CHAR_ZERO + {3'b000, d};
    end else begin
      code = CHAR_UPPER_A + {3'b000, d - 4'd10};
    end
    return code;
  endfunction

endpackage

// ===== hdl/n2a_dabble.sv =====
// ----------------------------------------------------------------------------
// n2a_dabble: bit-serial binary to bcd converter
// shift-and-add-3 over one input bit per cycle, msb first
// ----------------------------------------------------------------------------
module n2a_dabble import n2a_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int DEC_DIGITS  = dec_digits(NUMBER_BITS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUMBER_BITS-1:0]    value,
  output logic                      done,
  output logic [4*DEC_DIGITS-1:0]   bcd
);

  localparam int BCD_W = 4 * DEC_DIGITS;
  localparam int CNT_W = $clog2(NUMBER_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUMBER_BITS - 1);

  logic [NUMBER_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  // add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[NUMBER_BITS-2:0], 1'b0};
      bcd_nxt = {adj[BCD_W-2:0], mag_r[NUMBER_BITS-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ===== hdl/number_to_ascii_digits_core.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_digits_core: binary number to fixed-width ascii digit run
// one input word in, one output word per character, msd first, last marked
// ----------------------------------------------------------------------------
// each input word carries a kind (unsigned decimal, signed decimal, upper-case
// hex, binary), a number and a digit count; the core sends the low digit_count
// digits of the number as ascii characters, most significant first, with
// leading zeros, each tagged with its position in the run and tlast on the
// final one. signed decimal puts a '+' or '-' in front of the magnitude and
// sends the sign alone when the count is zero; the other kinds send nothing
// for a zero count. the count saturates at the digits of the widest value
// (10 decimal, 8 hex, 32 binary for 32-bit numbers). flow: one word is in
// work at a time; decimal kinds run a bit-serial double dabble over all
// NUMBER_BITS bits of the magnitude, then each character goes out when the
// output side is ready. the output register holds the last character while
// the core already takes the next input word.
// ----------------------------------------------------------------------------
module number_to_ascii_digits_core import n2a_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // lsb up: kind[2], number[NUMBER_BITS], digit_count[6], zero pad to bytes
  input  logic [((NUMBER_BITS + 15) / 8) * 8 - 1:0] in_tdata,

  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // lsb up: char_code[7], position[6], zero pad[3]
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  localparam int DEC_DIGITS = dec_digits(NUMBER_BITS);
  localparam int HEX_DIGITS = hex_digits(NUMBER_BITS);
  localparam int DEC_IW     = $clog2(DEC_DIGITS);
  localparam int HEX_IW     = $clog2(HEX_DIGITS);
  localparam int BIN_IW     = $clog2(NUMBER_BITS);

  // saturation limits, one bit wider than the count so 64 still fits
  localparam logic [6:0] DEC_MAX = 7'(DEC_DIGITS);
  localparam logic [6:0] HEX_MAX = 7'(HEX_DIGITS);
  localparam logic [6:0] BIN_MAX = 7'(NUMBER_BITS);

  // input field split
  kind_t                  in_kind;
  logic [NUMBER_BITS-1:0] in_number;
  logic [5:0]             in_count;

  assign in_kind   = kind_t'(in_tdata[1:0]);
  assign in_number = in_tdata[NUMBER_BITS+1:2];
  assign in_count  = in_tdata[NUMBER_BITS+7:NUMBER_BITS+2];

  state_t                 state_r, state_nxt;
  kind_t                  kind_r;
  logic                   neg_r;
  logic [NUMBER_BITS-1:0] val_r;
  logic [5:0]             rem_r, rem_nxt;     // digits still to send
  logic                   sign_r, sign_nxt;   // sign character still to send
  logic [5:0]             pos_r, pos_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [6:0]             out_char_r, out_char_nxt;
  logic [5:0]             out_pos_r, out_pos_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   in_neg;
  logic [NUMBER_BITS-1:0] in_mag;
  logic [6:0]             sat_max;
  logic [5:0]             sat_count;
  logic                   is_dec;
  logic                   conv_done;
  logic [4*DEC_DIGITS-1:0] bcd;
  logic                   emit_step;
  logic                   emit_last;

  assign accept = in_tvalid && in_tready;
  assign is_dec = (in_kind == KIND_UDEC) || (in_kind == KIND_SDEC);

  // magnitude of the incoming word; signed decimal flips negatives
  assign in_neg = (in_kind == KIND_SDEC) && in_number[NUMBER_BITS-1];
  assign in_mag = in_neg ? (~in_number + 1'b1) : in_number;

  // count saturation to the widest value in the chosen base
  always_comb begin
    case (in_kind)
      KIND_HEX: sat_max = HEX_MAX;
      KIND_BIN: sat_max = BIN_MAX;
      default:  sat_max = DEC_MAX;
    endcase
    if ({1'b0, in_count} > sat_max) begin
      sat_count = sat_max[5:0];
    end else begin
      sat_count = in_count;
    end
  end

  // bit-serial decimal conversion
  n2a_dabble #(
    .NUMBER_BITS (NUMBER_BITS),
    .DEC_DIGITS  (DEC_DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && is_dec),
    .value (in_mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // digit views of the bcd result and the held value
  logic [3:0]              bcd_dig [DEC_DIGITS];
  logic [3:0]              hex_dig [HEX_DIGITS];
  logic [4*HEX_DIGITS-1:0] val_pad;
  logic [5:0]              idx;
  logic [3:0]              cur_digit;

  assign val_pad = (4*HEX_DIGITS)'(val_r);
  assign idx     = rem_r - 1'b1;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_dig[i] = bcd[4*i +: 4];
    end
    for (int i = 0; i < HEX_DIGITS; i++) begin
      hex_dig[i] = val_pad[4*i +: 4];
    end
  end

  // digit at position rem-1, counted from the least significant one
  always_comb begin
    case (kind_r)
      KIND_HEX: cur_digit = hex_dig[idx[HEX_IW-1:0]];
      KIND_BIN: cur_digit = {3'b000, val_r[idx[BIN_IW-1:0]]};
      default:  cur_digit = bcd_dig[idx[DEC_IW-1:0]];
    endcase
  end

  // a character moves into the output register when it is free or drained
  assign emit_step = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign emit_last = sign_r ? (rem_r == 6'd0) : (rem_r == 6'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sat_count == 6'd0 && in_kind != KIND_SDEC) begin
            state_nxt = ST_IDLE;
          end else if (is_dec) begin
            state_nxt = ST_CONV;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_step && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and run counters
  always_comb begin
    rem_nxt        = rem_r;
    sign_nxt       = sign_r;
    pos_nxt        = pos_r;
    out_tvalid_nxt = out_tvalid_r;
    out_char_nxt   = out_char_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (accept) begin
      rem_nxt  = sat_count;
      sign_nxt = (in_kind == KIND_SDEC);
      pos_nxt  = '0;
    end else if (emit_step) begin
      out_tvalid_nxt = 1'b1;
      out_pos_nxt    = pos_r;
      out_last_nxt   = emit_last;
      pos_nxt        = pos_r + 1'b1;
      if (sign_r) begin
        out_char_nxt = neg_r ? CHAR_MINUS : CHAR_PLUS;
        sign_nxt     = 1'b0;
      end else begin
        out_char_nxt = digit_to_ascii(cur_digit);
        rem_nxt      = rem_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      neg_r  <= in_neg;
      val_r  <= in_number;
    end
    rem_r      <= rem_nxt;
    sign_r     <= sign_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_pos_r, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/sv/tb_number_to_ascii_digits_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_number_to_ascii_digits_core: self-checking bench for the ascii digit core
// drives number words with random gaps, back-pressures the character stream
// and checks every character word against an in-bench digit predictor
// ----------------------------------------------------------------------------
module tb_number_to_ascii_digits_core;
  import n2a_pkg::*;

  localparam int NUMBER_BITS = 32;
  localparam int IN_W        = ((NUMBER_BITS + 15) / 8) * 8;
  localparam int CYCLE_LIMIT = 1000000;
  // margin for a decimal word: a NUMBER_BITS-bit conversion plus up to 11 characters
  localparam int DRAIN_CYCLES = NUMBER_BITS + 48;
  localparam int MAX_PRINTS  = 30;

  // one expected character word
  typedef struct packed {
    logic [6:0] code;
    logic [5:0] pos;
    logic       last;
  } char_word_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  // lsb up: kind[2], number[32], digit_count[6]
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  // lsb up: char_code[7], position[6], zero pad[3]
  logic [15:0]     out_tdata;
  logic            out_tlast;

  char_word_t  pending_chars[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          tx_idle_pct    = 0;
  int          rx_idle_pct    = 0;

  number_to_ascii_digits_core #(
    .NUMBER_BITS(NUMBER_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 12 ns period
  always #6 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // prints one line per mismatch (capped) and counts all of them
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // expected character run for one number word, msd first
  task automatic predict_digits(input kind_t kind, input logic [31:0] number,
                                input logic [5:0] count);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [3:0]  digs[32];
    logic        neg;
    int          width_cap;
    int          n;
    int          pos;
    int          i;
    char_word_t  w;
    mag = number;
    neg = 1'b0;
    case (kind)
      KIND_HEX: begin
        radix = 32'd16;
        width_cap = 8;
      end
      KIND_BIN: begin
        radix = 32'd2;
        width_cap = 32;
      end
      default: begin
        radix = 32'd10;
        width_cap = 10;
      end
    endcase
    n = (count > width_cap) ? width_cap : int'(count);
    // signed decimal shows the magnitude; the most negative value stays 2^31
    if (kind == KIND_SDEC && number[31]) begin
      neg = 1'b1;
      mag = ~number + 32'd1;
    end
    // low digits first
    for (i = 0; i < n; i++) begin
      digs[i] = 4'(mag % radix);
      mag = mag / radix;
    end
    pos = 0;
    if (kind == KIND_SDEC) begin
      w.code = neg ? CHAR_MINUS : CHAR_PLUS;
      w.pos  = 6'(pos);
      w.last = (n == 0);
      pending_chars.push_back(w);
      pos++;
    end
    for (i = n; i > 0; i--) begin
      if (digs[i-1] < 4'd10) begin
        w.code = CHAR_ZERO + 7'(digs[i-1]);
      end else begin
        w.code = CHAR_UPPER_A + 7'(digs[i-1] - 4'd10);
      end
      w.pos  = 6'(pos);
      w.last = (i == 1);
      pending_chars.push_back(w);
      pos++;
    end
  endtask

  // character checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    char_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char word %h last %b", out_tdata, out_tlast));
      end else begin
        w = pending_chars.pop_front();
        if (out_tdata[6:0] !== w.code) begin
          report_mismatch($sformatf("char_code %h, expected %h (pos %0d)",
                                    out_tdata[6:0], w.code, w.pos));
        end
        if (out_tdata[12:7] !== w.pos) begin
          report_mismatch($sformatf("position %0d, expected %0d", out_tdata[12:7], w.pos));
        end
        if (out_tlast !== w.last) begin
          report_mismatch($sformatf("tlast %b, expected %b (pos %0d)",
                                    out_tlast, w.last, w.pos));
        end
      end
    end
  end

  // sends one number word after a random gap, predicts its run on acceptance
  task automatic send_word(input kind_t kind, input logic [31:0] number,
                           input logic [5:0] count);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'({$urandom, $urandom});
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {count, number, kind};
    do @(posedge clk); while (!in_tready);
    predict_digits(kind, number, count);
  endtask

  // drops tvalid for one cycle so the next burst starts clean
  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every predicted character has come back
  task automatic wait_for_chars();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // random value biased toward edges, small values and powers of ten
  function automatic logic [31:0] pick_number();
    logic [31:0] p10;
    int          e;
    case ($urandom_range(5))
      0: return $urandom_range(0, 9999);
      1: return $urandom >> $urandom_range(31);
      2: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      3: begin
        p10 = 32'd1;
        e = $urandom_range(9);
        repeat (e) p10 = p10 * 32'd10;
        return p10 - 32'($urandom_range(1)) + 32'($urandom_range(1));
      end
      default: return $urandom;
    endcase
  endfunction

  // count mostly up to two past the saturation limit, sometimes anywhere in 6 bits
  function automatic logic [5:0] pick_count(input kind_t kind);
    int cap;
    cap = (kind == KIND_HEX) ? 8 : (kind == KIND_BIN) ? 32 : 10;
    if ($urandom_range(9) < 7) begin
      return 6'($urandom_range(0, cap + 2));
    end
    return 6'($urandom_range(0, 63));
  endfunction

  // extremes of each field, every kind and the corner cases by name
  task automatic test_directed();
    send_word(KIND_UDEC, 32'd0,          6'd1);
    send_word(KIND_UDEC, 32'hFFFF_FFFF,  6'd10);
    send_word(KIND_UDEC, 32'hFFFF_FFFF,  6'd63);   // count saturates
    send_word(KIND_UDEC, 32'd1234567890, 6'd4);    // high digits dropped
    send_word(KIND_UDEC, 32'd42,         6'd0);    // nothing emitted
    send_word(KIND_SDEC, 32'd0,          6'd5);    // zero shows '+'
    send_word(KIND_SDEC, 32'd77,         6'd0);    // sign only
    send_word(KIND_SDEC, 32'h8000_0000,  6'd0);    // sign only, negative
    send_word(KIND_SDEC, 32'h8000_0000,  6'd10);   // most negative, full magnitude
    send_word(KIND_SDEC, 32'h8000_0000,  6'd3);
    send_word(KIND_SDEC, 32'hFFFF_FFFF,  6'd3);    // minus one
    send_word(KIND_SDEC, 32'h7FFF_FFFF,  6'd32);
    send_word(KIND_HEX,  32'hDEAD_BEEF,  6'd8);
    send_word(KIND_HEX,  32'h0123_ABCD,  6'd63);
    send_word(KIND_HEX,  32'hFFFF_FFFF,  6'd4);
    send_word(KIND_HEX,  32'h1234_5678,  6'd0);
    send_word(KIND_BIN,  32'hA5A5_A5A5,  6'd32);
    send_word(KIND_BIN,  32'hFFFF_FFFF,  6'd63);
    send_word(KIND_BIN,  32'h5A5A_5A5A,  6'd33);
    send_word(KIND_BIN,  32'd5,          6'd1);
    send_word(KIND_BIN,  32'd0,          6'd0);
    end_burst();
  endtask

  // random words with random content
  task automatic test_random(input int n_words);
    kind_t kind;
    repeat (n_words) begin
      kind = kind_t'($urandom_range(3));
      send_word(kind, pick_number(), pick_count(kind));
    end
    end_burst();
  endtask

  // sender holds off until the character stream has fully drained
  task automatic test_drain_pause();
    kind_t kind;
    repeat (6) begin
      kind = kind_t'($urandom_range(3));
      send_word(kind, pick_number(), pick_count(kind));
    end
    end_burst();
    wait_for_chars();
    repeat (6) begin
      kind = kind_t'($urandom_range(3));
      send_word(kind, pick_number(), pick_count(kind));
    end
    end_burst();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender gaps light, receiver stalls heavy
    tx_idle_pct = 36;
    rx_idle_pct = 76;
    test_directed();
    test_random(150);
    test_drain_pause();

    // sender gaps heavy, receiver stalls light
    tx_idle_pct = 76;
    rx_idle_pct = 36;
    test_random(150);

    // both sides flat out
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(150);

    wait_for_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
